/* rtl/ffha_pkg.sv */
// Shared types and constants for the first-fit heap allocator.
// Used by ffha_ctrl, ffha_dpath, ffha_checker and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

	localparam int REQ_W     = 12;   // request_bytes
	localparam int OFF_W     = 12;   // payload_offset / granted_offset
	localparam int ST_W      = 2;    // status
	localparam int NEED_W    = 9;    // granules needed by the largest request
	localparam int GRAN_SH   = 4;    // 16-byte granules
	localparam int NEED_BIAS = 23;   // header bytes plus granule minus one

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic            load;       // capture item, restart walk at granule 0
		logic            rd_cur;     // read header at walk position
		logic            take;       // hold current header for later steps
		logic            adv;        // step to next block
		logic            wr_head;    // mark current block allocated
		logic            wr_tail;    // write remainder header after split
		logic            rd_next;    // read header of following block
		logic            wr_free;    // write released and merged header
		logic            set_res;    // capture result
		logic [ST_W-1:0] res_st;
		logic            res_grant;  // result carries the payload offset
		logic            push;       // move result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op_free;
		logic pos_end;
		logic sz_zero;
		logic fits;
		logic split;
		logic pay_gt;
		logic pay_eq;
		logic cur_used;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/first_fit_heap_allocator_core.sv */
// Top level of the first-fit heap allocator: stream ports, ffha_ctrl, ffha_dpath.
// Depends on ffha_pkg.
//
//   channel | side   | tdata (low bit up)                    | tuser
//   s_axis  | input  | request_bytes[11:0], payload_offset   | op (0 alloc, 1 free)
//           |        | [23:12]                               |
//   m_axis  | output | granted_offset[11:0], status[13:12],  | -
//           |        | zeros[15:14]                          |
//
// Each header visited is read from memory, then compared. An alloc walks to
// the first free block that fits and marks it, with a remainder header on a
// split; a free walks to its block and merges it with free neighbours.
// No clearing pass after reset: the first header reads as one free block
// until it is written. A finished result waits in the output register while
// the next item is accepted; the walk stalls at its end only if that register
// is still full.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator_core #(
	parameter int HEAP_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // request_bytes[11:0], payload_offset[23:12]
	input  wire logic        s_axis_tuser,  // op[0]
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [15:0] m_axis_tdata   // granted_offset[11:0], status[13:12]
);

	ffha_pkg::cmd_t cmd;
	ffha_pkg::sts_t sts;

	logic [ffha_pkg::OFF_W-1:0] out_grant;
	logic [ffha_pkg::ST_W-1:0]  out_st;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffha_dpath #(
		.HEAP_BYTES (HEAP_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (s_axis_tuser),
		.in_req    (s_axis_tdata[11:0]),
		.in_off    (s_axis_tdata[23:12]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_grant (out_grant),
		.out_st    (out_st)
	);

	assign m_axis_tdata = {2'b00, out_st, out_grant};

endmodule

`default_nettype wire

/* rtl/ffha_ctrl.sv */
// Sequencer of the heap allocator: walks the header list and issues commands.
// Depends on ffha_pkg (cmd_t, sts_t, status codes).
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_ready,
	input  wire ffha_pkg::sts_t sts,
	output      ffha_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EV   = 3'd2;
	localparam logic [2:0] S_WRT  = 3'd3;
	localparam logic [2:0] S_RDN  = 3'd4;
	localparam logic [2:0] S_EVN  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				if (sts.pos_end) begin
					cmd.set_res = 1'b1;
					cmd.res_st  = sts.op_free ? ffha_pkg::ST_BADFREE : ffha_pkg::ST_NOSPACE;
					state_d     = S_FIN;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_EV;
				end
			end
			S_EV: begin
				cmd.take = 1'b1;
				if (sts.sz_zero) begin
					cmd.set_res = 1'b1;
					cmd.res_st  = sts.op_free ? ffha_pkg::ST_BADFREE : ffha_pkg::ST_NOSPACE;
					state_d     = S_FIN;
				end else if (!sts.op_free) begin
					if (sts.fits) begin
						cmd.wr_head   = 1'b1;
						cmd.set_res   = 1'b1;
						cmd.res_st    = ffha_pkg::ST_OK;
						cmd.res_grant = 1'b1;
						state_d       = sts.split ? S_WRT : S_FIN;
					end else begin
						cmd.adv = 1'b1;
						state_d = S_RD;
					end
				end else if (sts.pay_gt || (sts.pay_eq && !sts.cur_used)) begin
					cmd.set_res = 1'b1;
					cmd.res_st  = ffha_pkg::ST_BADFREE;
					state_d     = S_FIN;
				end else if (sts.pay_eq) begin
					state_d = S_RDN;
				end else begin
					cmd.adv = 1'b1;
					state_d = S_RD;
				end
			end
			S_WRT: begin
				cmd.wr_tail = 1'b1;
				state_d     = S_FIN;
			end
			S_RDN: begin
				cmd.rd_next = 1'b1;
				state_d     = S_EVN;
			end
			S_EVN: begin
				cmd.wr_free = 1'b1;
				cmd.set_res = 1'b1;
				cmd.res_st  = ffha_pkg::ST_OK;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/ffha_dpath.sv */
// Datapath of the heap allocator: header memory, walk registers, compares,
// result and output registers. Depends on ffha_pkg; driven by ffha_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ffha_dpath #(
	parameter int HEAP_BYTES = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_op,
	input  wire logic [ffha_pkg::REQ_W-1:0]  in_req,
	input  wire logic [ffha_pkg::OFF_W-1:0]  in_off,
	input  wire ffha_pkg::cmd_t              cmd,
	output      ffha_pkg::sts_t              sts,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [ffha_pkg::OFF_W-1:0]  out_grant,
	output      logic [ffha_pkg::ST_W-1:0]   out_st
);

	localparam int GRANULES = HEAP_BYTES / 16;
	localparam int AW  = $clog2(GRANULES);              // memory index
	localparam int PW  = $clog2(GRANULES + 1);          // walk position, holds GRANULES
	localparam int SW  = PW;                            // block size in granules
	localparam int EW  = SW + 1;                        // header entry: size, used bit
	localparam int CW  = (SW > ffha_pkg::NEED_W) ? SW : ffha_pkg::NEED_W;
	localparam int YW  = (PW + ffha_pkg::GRAN_SH > ffha_pkg::OFF_W) ?
	                     PW + ffha_pkg::GRAN_SH : ffha_pkg::OFF_W;
	localparam int SUMW = ffha_pkg::REQ_W + 1;

	// header store; entry 0 reads as one free block spanning the heap until written
	logic [EW-1:0] mem_q [GRANULES];
	logic [EW-1:0] rdata_s1;
	logic          rinit_s1;
	logic          h0_init_q;
	logic          nrd_s1;

	logic                       op_q;
	logic [ffha_pkg::NEED_W-1:0] need_q;
	logic [ffha_pkg::OFF_W-1:0] off_q;
	logic [PW-1:0]              pos_q;
	logic [PW-1:0]              prev_pos_q;
	logic [SW-1:0]              prev_sz_q;
	logic                       prev_free_q;
	logic [SW-1:0]              cur_sz_q;
	logic [ffha_pkg::ST_W-1:0]  res_st_q;
	logic [ffha_pkg::OFF_W-1:0] res_grant_q;
	logic                       out_valid_q;
	logic [ffha_pkg::ST_W-1:0]  out_st_q;
	logic [ffha_pkg::OFF_W-1:0] out_grant_q;

	logic [SUMW-1:0]            need_sum;
	logic [EW-1:0]              cur_e;
	logic [SW-1:0]              cur_sz;
	logic                       cur_used;
	logic [YW-1:0]              pay;
	logic [PW-1:0]              next_pos;
	logic                       next_in;
	logic [SW-1:0]              need_sz;
	logic [SW-1:0]              merged;
	logic                       nxt_free;
	logic                       re, we;
	logic [AW-1:0]              raddr, waddr;
	logic [EW-1:0]              wdata;

	assign need_sum = {1'b0, in_req} + SUMW'(ffha_pkg::NEED_BIAS);

	assign cur_e    = rinit_s1 ? {SW'(GRANULES), 1'b0} : rdata_s1;
	assign cur_sz   = cur_e[EW-1:1];
	assign cur_used = cur_e[0];
	assign need_sz  = SW'(need_q);

	assign pay      = YW'({pos_q, 4'b1000});
	assign next_pos = pos_q + PW'(cur_sz_q);
	assign next_in  = (next_pos < PW'(GRANULES));

	assign nxt_free = nrd_s1 && (cur_sz != '0) && !cur_used;
	assign merged   = cur_sz_q + (nxt_free ? cur_sz : SW'(0));

	// memory port control
	always_comb begin
		re    = cmd.rd_cur || (cmd.rd_next && next_in);
		raddr = cmd.rd_next ? next_pos[AW-1:0] : pos_q[AW-1:0];
		we    = cmd.wr_head || cmd.wr_tail || cmd.wr_free;
		waddr = pos_q[AW-1:0];
		wdata = {need_sz, 1'b1};
		if (cmd.wr_tail) begin
			waddr = AW'(pos_q + PW'(need_sz));
			wdata = {SW'(cur_sz_q - need_sz), 1'b0};
		end else if (cmd.wr_free) begin
			if (prev_free_q) begin
				waddr = prev_pos_q[AW-1:0];
				wdata = {SW'(prev_sz_q + merged), 1'b0};
			end else begin
				wdata = {merged, 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h0_init_q <= 1'b1;
			rinit_s1  <= 1'b0;
			nrd_s1    <= 1'b0;
		end else begin
			if (we && (waddr == '0)) begin
				h0_init_q <= 1'b0;
			end
			if (re) begin
				rinit_s1 <= h0_init_q && (raddr == '0);
			end
			if (cmd.rd_next) begin
				nrd_s1 <= next_in;
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_op;
			need_q <= need_sum[SUMW-1:ffha_pkg::GRAN_SH];
			off_q  <= in_off;
		end
		if (cmd.take) begin
			cur_sz_q <= cur_sz;
		end
		if (cmd.adv) begin
			prev_pos_q <= pos_q;
			prev_sz_q  <= cur_sz;
		end
		if (cmd.set_res) begin
			res_st_q    <= cmd.res_st;
			res_grant_q <= cmd.res_grant ? pay[ffha_pkg::OFF_W-1:0] : '0;
		end
		if (cmd.push) begin
			out_st_q    <= res_st_q;
			out_grant_q <= res_grant_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			prev_free_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				pos_q       <= '0;
				prev_free_q <= 1'b0;
			end else if (cmd.adv) begin
				pos_q       <= pos_q + PW'(cur_sz);
				prev_free_q <= !cur_used;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.op_free  = (op_q == ffha_pkg::OP_FREE);
		sts.pos_end  = (pos_q >= PW'(GRANULES));
		sts.sz_zero  = (cur_sz == '0);
		sts.fits     = !cur_used && (CW'(cur_sz) >= CW'(need_q));
		sts.split    = (CW'(cur_sz) > CW'(need_q));
		sts.pay_gt   = (pay > YW'(off_q));
		sts.pay_eq   = (pay == YW'(off_q));
		sts.cur_used = cur_used;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_grant = out_grant_q;
	assign out_st    = out_st_q;

endmodule

`default_nettype wire

/* rtl/ffha_checker.sv */
// Port-level checks for first_fit_heap_allocator_core, attached by bind.
// Depends on ffha_pkg status codes.
`timescale 1ns / 1ps
`default_nettype none

module ffha_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);

	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one item at a time: busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after accept");

	// only defined status codes, padding zero
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0 || m_axis_tdata[15:12] == 4'd1
		|| m_axis_tdata[15:12] == 4'd2)
		else $error("bad status code");

	// a granted offset only on success, and always a payload position
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[11:0] != 12'd0 |->
		m_axis_tdata[13:12] == ffha_pkg::ST_OK && m_axis_tdata[3:0] == 4'd8)
		else $error("granted offset with failure or misaligned");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_chk (.*);

`default_nettype wire
